### hdl/ps2_scan_code_key_decoder_macros.svh
// ----------------------------------------------------------------------------
// PS/2 key decoder assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef PS2_SCAN_CODE_KEY_DECODER_MACROS_SVH
`define PS2_SCAN_CODE_KEY_DECODER_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define PS2KD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ps2kd assertion failed");

// next-cycle implication
`define PS2KD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ps2kd assertion failed");

`else

`define PS2KD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PS2KD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hdl/ps2kd_pkg.sv
// ----------------------------------------------------------------------------
// ps2kd_pkg
// Types, constants and scan code tables for the PS/2 set-1 key decoder.
// ----------------------------------------------------------------------------
package ps2kd_pkg;

  localparam int RING_DEPTH = 256;
  localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  typedef enum logic [1:0] {
    OP_SCAN   = 2'd0,
    OP_INJECT = 2'd1,
    OP_POP    = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic       event_valid;
    logic [8:0] event_key;
    logic       pop_valid;
    logic [8:0] pop_key;
    logic       key_waiting;
    logic       alt_held;
  } out_word_t;

  // scan codes
  localparam logic [7:0] SC_PREFIX   = 8'hE0;
  localparam logic [7:0] SC_LSHIFT   = 8'h2A;
  localparam logic [7:0] SC_RSHIFT   = 8'h36;
  localparam logic [7:0] SC_CTRL     = 8'h1D;
  localparam logic [7:0] SC_ALT      = 8'h38;
  localparam logic [7:0] SC_CAPS     = 8'h3A;
  localparam logic [7:0] SC_TAB      = 8'h0F;
  localparam logic [7:0] SC_MAP_LEN  = 8'd58;

  // special key values
  localparam logic [8:0] NAV_UP      = 9'd256;
  localparam logic [8:0] NAV_DN      = 9'd257;
  localparam logic [8:0] NAV_LT      = 9'd258;
  localparam logic [8:0] NAV_RT      = 9'd259;
  localparam logic [8:0] NAV_BEGIN   = 9'd260;
  localparam logic [8:0] NAV_END     = 9'd261;
  localparam logic [8:0] NAV_DEL     = 9'd262;
  localparam logic [8:0] NAV_PAGE_UP = 9'd263;
  localparam logic [8:0] NAV_PAGE_DN = 9'd264;
  localparam logic [8:0] KEY_ALT_TAB = 9'd265;
  localparam logic [8:0] KEY_NONE    = 9'd0;

  // letters b c f h l n q r s t u w y z take a control code
  localparam logic [25:0] CTRL_LETTERS = 26'b11_0101_1111_0010_1000_1010_0110;

  function automatic logic [7:0] plain_char(input logic [5:0] sc);
    logic [7:0] c;
    case (sc)
      6'd1:  c = 8'h1B;  6'd2:  c = 8'h31;  6'd3:  c = 8'h32;  6'd4:  c = 8'h33;
      6'd5:  c = 8'h34;  6'd6:  c = 8'h35;  6'd7:  c = 8'h36;  6'd8:  c = 8'h37;
      6'd9:  c = 8'h38;  6'd10: c = 8'h39;  6'd11: c = 8'h30;  6'd12: c = 8'h2D;
      6'd13: c = 8'h3D;  6'd14: c = 8'h08;  6'd15: c = 8'h09;  6'd16: c = 8'h71;
      6'd17: c = 8'h77;  6'd18: c = 8'h65;  6'd19: c = 8'h72;  6'd20: c = 8'h74;
      6'd21: c = 8'h79;  6'd22: c = 8'h75;  6'd23: c = 8'h69;  6'd24: c = 8'h6F;
      6'd25: c = 8'h70;  6'd26: c = 8'h5B;  6'd27: c = 8'h5D;  6'd28: c = 8'h0A;
      6'd30: c = 8'h61;  6'd31: c = 8'h73;  6'd32: c = 8'h64;  6'd33: c = 8'h66;
      6'd34: c = 8'h67;  6'd35: c = 8'h68;  6'd36: c = 8'h6A;  6'd37: c = 8'h6B;
      6'd38: c = 8'h6C;  6'd39: c = 8'h3B;  6'd40: c = 8'h27;  6'd41: c = 8'h60;
      6'd43: c = 8'h5C;  6'd44: c = 8'h7A;  6'd45: c = 8'h78;  6'd46: c = 8'h63;
      6'd47: c = 8'h76;  6'd48: c = 8'h62;  6'd49: c = 8'h6E;  6'd50: c = 8'h6D;
      6'd51: c = 8'h2C;  6'd52: c = 8'h2E;  6'd53: c = 8'h2F;  6'd55: c = 8'h2A;
      6'd57: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] shift_char(input logic [5:0] sc);
    logic [7:0] c;
    c = plain_char(sc);
    if (c inside {[8'h61:8'h7A]}) begin
      c = c - 8'h20;
    end else begin
      case (sc)
        6'd2:  c = 8'h21;  6'd3:  c = 8'h40;  6'd4:  c = 8'h23;  6'd5:  c = 8'h24;
        6'd6:  c = 8'h25;  6'd7:  c = 8'h5E;  6'd8:  c = 8'h26;  6'd9:  c = 8'h2A;
        6'd10: c = 8'h28;  6'd11: c = 8'h29;  6'd12: c = 8'h5F;  6'd13: c = 8'h2B;
        6'd26: c = 8'h7B;  6'd27: c = 8'h7D;  6'd39: c = 8'h3A;  6'd40: c = 8'h22;
        6'd41: c = 8'h7E;  6'd43: c = 8'h7C;  6'd51: c = 8'h3C;  6'd52: c = 8'h3E;
        6'd53: c = 8'h3F;
        default: c = c;
      endcase
    end
    return c;
  endfunction

  function automatic logic [7:0] decode_char(input logic [7:0] sc, input logic shift,
                                             input logic caps, input logic ctrl);
    logic [7:0] c;
    logic [7:0] low;
    logic [4:0] idx;
    c = 8'h00;
    if (sc < SC_MAP_LEN) begin
      c = shift ? shift_char(sc[5:0]) : plain_char(sc[5:0]);
    end
    if (caps && (c inside {[8'h61:8'h7A]})) begin
      c = c - 8'h20;
    end else if (caps && (c inside {[8'h41:8'h5A]})) begin
      c = c + 8'h20;
    end
    low = c | 8'h20;
    idx = 5'(low - 8'h61);
    if (ctrl && (low inside {[8'h61:8'h7A]}) && CTRL_LETTERS[idx]) begin
      c = low & 8'h1F;
    end
    return c;
  endfunction

  function automatic logic [8:0] ext_key(input logic [7:0] sc);
    logic [8:0] k;
    case (sc)
      8'h48:   k = NAV_UP;
      8'h50:   k = NAV_DN;
      8'h4B:   k = NAV_LT;
      8'h4D:   k = NAV_RT;
      8'h47:   k = NAV_BEGIN;
      8'h4F:   k = NAV_END;
      8'h53:   k = NAV_DEL;
      8'h49:   k = NAV_PAGE_UP;
      8'h51:   k = NAV_PAGE_DN;
      default: k = KEY_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

### hdl/ps2_scan_code_key_decoder.sv
// Throughput 1 word per cycle while the output is not stalled. State update,
// ring write and ring read happen at the accept edge; the registered ring read
// is held beside stage 1, and both drain into the output register.
// A stalled output holds up to two words before in_ready drops.
// rst_n (synchronous) clears pointers, modifiers, prefix, gui_mode and valids;
// the ring contents are not cleared.
// ----------------------------------------------------------------------------
// ps2_scan_code_key_decoder
// PS/2 set-1 scan code decoder with modifier tracking and a key ring.
// ----------------------------------------------------------------------------
`include "ps2_scan_code_key_decoder_macros.svh"

module ps2_scan_code_key_decoder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ps2kd_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ps2kd_pkg::out_word_t out_data
);

  localparam int PW = ps2kd_pkg::PTR_W;

  logic [8:0]    mem [ps2kd_pkg::RING_DEPTH];
  logic [8:0]    mem_rd_r;

  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic          shift_r, shift_nxt;
  logic          ctrl_r, ctrl_nxt;
  logic          alt_r, alt_nxt;
  logic          caps_r, caps_nxt;
  logic          prefix_r, prefix_nxt;
  logic          gui_r;

  logic          s1_v_r;
  logic          s1_ev_v_r, s1_pop_v_r, s1_wait_r, s1_alt_r;
  logic [8:0]    s1_ev_k_r;
  logic          out_v_r;
  ps2kd_pkg::out_word_t out_data_r;

  logic          in_acc, s1_move;
  logic          ev_v, put, wr_en, pop_ok;
  logic [8:0]    ev_k, put_key, ekey;
  logic [7:0]    ch;
  ps2kd_pkg::opcode_t op;

  assign op       = ps2kd_pkg::opcode_t'(in_data.opcode);
  assign s1_move  = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_move;
  assign in_acc   = in_valid && in_ready;
  assign ekey     = ps2kd_pkg::ext_key(in_data.data_byte);
  assign ch       = ps2kd_pkg::decode_char(in_data.data_byte, shift_r, caps_r, ctrl_r);

  always_comb begin
    ev_v       = 1'b0;
    ev_k       = ps2kd_pkg::KEY_NONE;
    put        = 1'b0;
    put_key    = ps2kd_pkg::KEY_NONE;
    pop_ok     = 1'b0;
    shift_nxt  = shift_r;
    ctrl_nxt   = ctrl_r;
    alt_nxt    = alt_r;
    caps_nxt   = caps_r;
    prefix_nxt = prefix_r;
    rd_ptr_nxt = rd_ptr_r;
    case (op)
      ps2kd_pkg::OP_SCAN: begin
        if (in_data.data_byte == ps2kd_pkg::SC_PREFIX) begin
          prefix_nxt = 1'b1;
        end else if (prefix_r) begin
          // known extended make code: key; extended release or unknown code: no key
          prefix_nxt = 1'b0;
          if (!in_data.data_byte[7] && ekey != ps2kd_pkg::KEY_NONE) begin
            ev_v    = gui_r;
            ev_k    = gui_r ? ekey : ps2kd_pkg::KEY_NONE;
            put     = !gui_r;
            put_key = ekey;
          end
        end else if (in_data.data_byte[7]) begin
          if ({1'b0, in_data.data_byte[6:0]} inside {ps2kd_pkg::SC_LSHIFT,
                                                     ps2kd_pkg::SC_RSHIFT}) begin
            shift_nxt = 1'b0;
          end
          if ({1'b0, in_data.data_byte[6:0]} == ps2kd_pkg::SC_CTRL) begin
            ctrl_nxt = 1'b0;
          end
          if ({1'b0, in_data.data_byte[6:0]} == ps2kd_pkg::SC_ALT) begin
            alt_nxt = 1'b0;
          end
        end else if (in_data.data_byte inside {ps2kd_pkg::SC_LSHIFT,
                                               ps2kd_pkg::SC_RSHIFT}) begin
          shift_nxt = 1'b1;
        end else if (in_data.data_byte == ps2kd_pkg::SC_CTRL) begin
          ctrl_nxt = 1'b1;
        end else if (in_data.data_byte == ps2kd_pkg::SC_ALT) begin
          alt_nxt = 1'b1;
        end else if (in_data.data_byte == ps2kd_pkg::SC_CAPS) begin
          caps_nxt = !caps_r;
        end else if (alt_r && in_data.data_byte == ps2kd_pkg::SC_TAB) begin
          // drop alt-tab outside gui mode
          ev_v = gui_r;
          ev_k = gui_r ? ps2kd_pkg::KEY_ALT_TAB : ps2kd_pkg::KEY_NONE;
        end else if (ch != 8'h00) begin
          ev_v    = gui_r;
          ev_k    = gui_r ? {1'b0, ch} : ps2kd_pkg::KEY_NONE;
          put     = !gui_r;
          put_key = {1'b0, ch};
        end
      end
      ps2kd_pkg::OP_INJECT: begin
        put     = 1'b1;
        put_key = {1'b0, in_data.data_byte};
      end
      ps2kd_pkg::OP_POP: begin
        if (rd_ptr_r != wr_ptr_r) begin
          pop_ok     = 1'b1;
          rd_ptr_nxt = ps2kd_pkg::ring_next(rd_ptr_r);
        end
      end
      default: begin
      end
    endcase
    // keep one slot free; drop the key when full
    wr_en      = put && (ps2kd_pkg::ring_next(wr_ptr_r) != rd_ptr_r);
    wr_ptr_nxt = wr_en ? ps2kd_pkg::ring_next(wr_ptr_r) : wr_ptr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      shift_r  <= 1'b0;
      ctrl_r   <= 1'b0;
      alt_r    <= 1'b0;
      caps_r   <= 1'b0;
      prefix_r <= 1'b0;
      gui_r    <= 1'b0;
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        gui_r <= cfg_wdata;
      end
      if (in_acc) begin
        wr_ptr_r <= wr_ptr_nxt;
        rd_ptr_r <= rd_ptr_nxt;
        shift_r  <= shift_nxt;
        ctrl_r   <= ctrl_nxt;
        alt_r    <= alt_nxt;
        caps_r   <= caps_nxt;
        prefix_r <= prefix_nxt;
      end
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_move) begin
        s1_v_r <= 1'b0;
      end
      if (!out_v_r || out_ready) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  // ring storage and registered read
  always_ff @(posedge clk) begin
    if (in_acc && wr_en) begin
      mem[wr_ptr_r] <= put_key;
    end
    if (in_acc && pop_ok) begin
      mem_rd_r <= mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ev_v_r  <= ev_v;
      s1_ev_k_r  <= ev_k;
      s1_pop_v_r <= pop_ok;
      s1_wait_r  <= (rd_ptr_nxt != wr_ptr_nxt);
      s1_alt_r   <= alt_nxt;
    end
    if (s1_move) begin
      out_data_r.event_valid <= s1_ev_v_r;
      out_data_r.event_key   <= s1_ev_k_r;
      out_data_r.pop_valid   <= s1_pop_v_r;
      out_data_r.pop_key     <= s1_pop_v_r ? mem_rd_r : ps2kd_pkg::KEY_NONE;
      out_data_r.key_waiting <= s1_wait_r;
      out_data_r.alt_held    <= s1_alt_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  `PS2KD_ASSERT_IMP(a_one_kind, clk, rst_n, out_v_r, !(out_data_r.event_valid && out_data_r.pop_valid))
  `PS2KD_ASSERT_NXT(a_full_drop, clk, rst_n, in_acc && op == ps2kd_pkg::OP_INJECT && ps2kd_pkg::ring_next(wr_ptr_r) == rd_ptr_r, $stable(wr_ptr_r))
  `PS2KD_ASSERT_NXT(a_empty_pop, clk, rst_n, in_acc && op == ps2kd_pkg::OP_POP && rd_ptr_r == wr_ptr_r, $stable(rd_ptr_r))
  `PS2KD_ASSERT_IMP(a_stall_full, clk, rst_n, !in_ready, s1_v_r && out_v_r)

endmodule
